FILE: rtl/doiq_pkg.sv
// Package for the deadline ordered input queue: payload structs, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package doiq_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_ROUTES = 8;
  localparam int RIDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int RCNT_W = $clog2(MAX_ROUTES + 1);
  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  localparam logic [1:0] OP_ARRIVE = 2'd0;
  localparam logic [1:0] OP_ROUTE  = 2'd1;
  localparam logic [1:0] OP_SWITCH = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [1:0] RK_INJECT = 2'd0;
  localparam logic [1:0] RK_SWREQ  = 2'd1;
  localparam logic [1:0] RK_RTREQ  = 2'd2;
  localparam logic [1:0] RK_DROP   = 2'd3;

  localparam logic CFG_SPEEDUP = 1'b0;
  localparam logic CFG_VCS     = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] flit_tag;
    logic [31:0] deadline;
    logic [5:0]  route_port;
    logic [3:0]  route_vc;
    logic        route_last;
    logic        granted;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] out_tag;
    logic [9:0]  out_port;
    logic [3:0]  out_vc;
    logic [9:0]  out_vc_id;
    logic [31:0] out_deadline;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] deadline;
  } flit_t;

  // Control between the sequencer and the queue memory.
  typedef struct packed {
    logic             rd_en;
    logic [QIDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [QIDX_W-1:0] wr_addr;
    flit_t            wr_data;
  } qmem_ctl_t;
endpackage

FILE: rtl/doiq_ram.sv
// Queue entry memory: one write port, one registered read port.
// Depends on doiq_pkg.
`timescale 1ns / 1ps
module doiq_ram (
  input  logic               clk,
  input  doiq_pkg::qmem_ctl_t ctl,
  output doiq_pkg::flit_t    rd_data
);
  import doiq_pkg::*;
  flit_t mem [QUEUE_DEPTH];
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end
endmodule

FILE: rtl/doiq_mod.sv
// Serial modulo unit: lfsr value modulo a small count, one quotient bit per cycle.
// Depends on doiq_pkg.
`timescale 1ns / 1ps
module doiq_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [15:0]                 num,
  input  logic [doiq_pkg::RCNT_W-1:0] den,
  output logic                        done,
  output logic [doiq_pkg::RIDX_W-1:0] rem
);
  import doiq_pkg::*;
  logic [15:0] shreg;
  logic [RCNT_W:0] acc;
  logic [RCNT_W:0] acc_sh;
  logic [4:0] cnt;
  logic busy;
  always_comb begin
    acc_sh = {acc[RCNT_W-1:0], shreg[15]};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy  <= 1'b1;
        shreg <= num;
        acc   <= '0;
        cnt   <= 5'd16;
      end else if (busy) begin
        shreg <= {shreg[14:0], 1'b0};
        if (acc_sh >= {1'b0, den}) begin
          acc <= acc_sh - {1'b0, den};
        end else begin
          acc <= acc_sh;
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rem = acc[RIDX_W-1:0];
endmodule

FILE: rtl/deadline_ordered_input_queue_unit.sv
// Top level of the deadline ordered input queue with route and switch stages.
// Depends on doiq_pkg, doiq_ram, doiq_mod.
`timescale 1ns / 1ps
// Usage:
//   Assert start with an item on in_item while busy is low; the transfer
//   happens on that edge. Each result is shown on res_item for one cycle,
//   marked by res_valid; last_of_run flags the final result of an item.
//   The receiver cannot stall; results are never held.
//   Configuration: cfg_we with cfg_index (0 speedup, 1 VCs per port) and
//   cfg_data, taken at once; write only while idle, the block does not check.
//   Timing: the queue lives in a synchronous memory. An arrival walks the
//   sorted queue from the tail, a read, then a shift-write, per place,
//   while busy stays high; a drop on a full queue is busy for one cycle.
//   A tick reinserts a denied flit the same way, or drops it on a full
//   queue, picks a route with a 16 step serial modulo, and pops the head
//   by moving every entry down one place, each with a read, then a write.
//   Route and switch responses are busy for one cycle. The memory port and
//   the serial modulo set how long busy stays high.
//   Reset: queue empty, both stages empty, LFSR at its seed, config at
//   defaults. Memory contents are left as they are.
module deadline_ordered_input_queue_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  doiq_pkg::in_item_t  in_item,
  output logic                busy,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [4:0]          cfg_data,
  output logic                res_valid,
  output doiq_pkg::out_item_t res_item
);
  import doiq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CHK, S_POP_RD, S_POP_MV, S_POP_HEAD, S_SW_DONE,
    S_ADV, S_MOD, S_ADV_OUT, S_LOAD, S_FIN
  } state_t;

  state_t state;
  logic speedup;
  logic [4:0] vcs;
  logic [QCNT_W-1:0] qcount;
  logic [1:0] rs_state, ss_state;
  flit_t rs_flit, ss_flit, ins_flit;
  logic [RCNT_W-1:0] cand_cnt;
  logic [5:0] cand_port [MAX_ROUTES];
  logic [3:0] cand_vc [MAX_ROUTES];
  logic [9:0] ss_port, ss_vc_id;
  logic [3:0] ss_vc;
  logic ss_grant;
  logic [15:0] lfsr;
  logic [QCNT_W-1:0] pos;
  logic ins_from_sw;      // insertion is a reinsertion on a tick
  qmem_ctl_t qctl;
  flit_t qrd;
  logic mod_go, mod_done;
  logic [RIDX_W-1:0] mod_rem;
  logic [15:0] lfsr_next;
  logic [RIDX_W-1:0] pick;
  logic [9:0] vcid_calc;
  logic sw_last;          // no switch or routing request follows the switch result

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_WAIT_REQ = 2'd1;
  localparam logic [1:0] ST_WAIT_RESP = 2'd2;
  localparam logic [1:0] ST_READY = 2'd3;

  doiq_ram u_ram (.clk(clk), .ctl(qctl), .rd_data(qrd));
  doiq_mod u_mod (.clk(clk), .rst(rst), .go(mod_go), .num(lfsr), .den(cand_cnt),
                  .done(mod_done), .rem(mod_rem));

  assign busy = (state != S_IDLE);
  assign lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
  assign pick = (cand_cnt == '0) ? '0 : mod_rem;
  assign vcid_calc = 10'(({4'd0, cand_port[pick]} * {5'd0, vcs}) + 10'(cand_vc[pick]));
  // After the switch stage empties, a ready route stage advances, and an
  // empty route stage loads the head of a non-empty queue.
  assign sw_last = !(rs_state == ST_READY || (rs_state == ST_EMPTY && qcount != '0));

  // Memory port control, driven from the sequencer state.
  always_comb begin
    qctl = '0;
    case (state)
      S_INS_RD: begin
        qctl.rd_en = (pos != '0);
        qctl.rd_addr = QIDX_W'(pos - 1'b1);
      end
      S_INS_CHK: begin
        qctl.wr_en = 1'b1;
        qctl.wr_addr = QIDX_W'(pos);
        qctl.wr_data = (pos != '0 && qrd.deadline > ins_flit.deadline) ? qrd : ins_flit;
      end
      S_POP_RD: begin
        qctl.rd_en = 1'b1;
        qctl.rd_addr = QIDX_W'(pos);
      end
      S_POP_MV: begin
        qctl.wr_en = (pos != '0);
        qctl.wr_addr = QIDX_W'(pos - 1'b1);
        qctl.wr_data = qrd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      speedup <= 1'b0;
      vcs <= 5'd4;
      qcount <= '0;
      rs_state <= ST_EMPTY;
      ss_state <= ST_EMPTY;
      rs_flit <= '0;
      ss_flit <= '0;
      cand_cnt <= '0;
      ss_port <= '0;
      ss_vc <= '0;
      ss_vc_id <= '0;
      ss_grant <= 1'b0;
      lfsr <= LFSR_SEED;
      res_valid <= 1'b0;
      mod_go <= 1'b0;
      ins_from_sw <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      mod_go <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_SPEEDUP) speedup <= cfg_data[0];
        else vcs <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            case (in_item.opcode)
              OP_ARRIVE: begin
                ins_flit <= '{in_item.flit_tag, in_item.deadline};
                ins_from_sw <= 1'b0;
                pos <= qcount;
                if (qcount == QCNT_W'(QUEUE_DEPTH)) begin
                  // full: drop the arrival at once
                  res_valid <= 1'b1;
                  res_item <= '{RK_DROP, in_item.flit_tag, 10'd0, 4'd0, 10'd0,
                                in_item.deadline, 1'b1};
                  state <= S_FIN;
                end else begin
                  state <= S_INS_RD;
                end
              end
              OP_ROUTE: begin
                if (rs_state == ST_WAIT_RESP) begin
                  if (cand_cnt < RCNT_W'(MAX_ROUTES)) begin
                    cand_port[cand_cnt[RIDX_W-1:0]] <= in_item.route_port;
                    cand_vc[cand_cnt[RIDX_W-1:0]] <= in_item.route_vc;
                    cand_cnt <= cand_cnt + 1'b1;
                  end
                  if (in_item.route_last) rs_state <= ST_READY;
                end
                state <= S_FIN;
              end
              OP_SWITCH: begin
                if (ss_state == ST_WAIT_RESP) begin
                  ss_grant <= in_item.granted;
                  ss_state <= ST_READY;
                end
                state <= S_FIN;
              end
              default: begin
                state <= S_SW_DONE;
              end
            endcase
          end
        end
        S_INS_RD: begin
          state <= S_INS_CHK;
        end
        S_INS_CHK: begin
          // shift the larger entry up, or settle the new one here
          if (pos != '0 && qrd.deadline > ins_flit.deadline) begin
            pos <= pos - 1'b1;
            state <= S_INS_RD;
          end else begin
            qcount <= qcount + 1'b1;
            state <= ins_from_sw ? S_ADV : S_FIN;
          end
        end
        S_SW_DONE: begin
          state <= S_ADV;
          if (ss_state == ST_READY) begin
            ss_state <= ST_EMPTY;
            ss_grant <= 1'b0;
            ss_port <= '0; ss_vc <= '0; ss_vc_id <= '0; ss_flit <= '0;
            if (ss_grant) begin
              res_valid <= 1'b1;
              res_item <= '{RK_INJECT, ss_flit.tag, ss_port, ss_vc, ss_vc_id,
                            ss_flit.deadline, sw_last};
            end else if (qcount == QCNT_W'(QUEUE_DEPTH)) begin
              res_valid <= 1'b1;
              res_item <= '{RK_DROP, ss_flit.tag, 10'd0, 4'd0, 10'd0,
                            ss_flit.deadline, sw_last};
            end else begin
              ins_flit <= ss_flit;
              ins_from_sw <= 1'b1;
              pos <= qcount;
              state <= S_INS_RD;
            end
          end
        end
        S_ADV: begin
          if (ss_state == ST_EMPTY && rs_state == ST_READY) begin
            lfsr <= lfsr_next;
            mod_go <= 1'b1;
            state <= S_MOD;
          end else begin
            state <= S_LOAD;
          end
        end
        S_MOD: begin
          if (mod_done) state <= S_ADV_OUT;
        end
        S_ADV_OUT: begin
          ss_vc_id <= vcid_calc;
          ss_port <= speedup ? vcid_calc : {4'd0, cand_port[pick]};
          ss_vc <= cand_vc[pick];
          ss_flit <= rs_flit;
          ss_grant <= 1'b0;
          ss_state <= ST_WAIT_RESP;
          res_valid <= 1'b1;
          // last unless the emptied route stage loads a queued flit
          res_item <= '{RK_SWREQ, rs_flit.tag,
                        speedup ? vcid_calc : {4'd0, cand_port[pick]},
                        cand_vc[pick], vcid_calc, rs_flit.deadline, qcount == '0};
          rs_state <= ST_EMPTY;
          rs_flit <= '0;
          cand_cnt <= '0;
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (rs_state == ST_EMPTY && qcount != '0) begin
            pos <= '0;
            state <= S_POP_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_POP_RD: begin
          state <= S_POP_MV;
        end
        S_POP_MV: begin
          // hold the head, move the rest down one place
          if (pos == '0) rs_flit <= qrd;
          if (pos + 1'b1 < qcount) begin
            pos <= pos + 1'b1;
            state <= S_POP_RD;
          end else begin
            state <= S_POP_HEAD;
          end
        end
        S_POP_HEAD: begin
          qcount <= qcount - 1'b1;
          cand_cnt <= '0;
          rs_state <= ST_WAIT_RESP;
          res_valid <= 1'b1;
          res_item <= '{RK_RTREQ, rs_flit.tag, 10'd0, 4'd0, 10'd0,
                        rs_flit.deadline, 1'b1};
          state <= S_FIN;
        end
        S_FIN: begin
          // return to idle; the final result already carries its flag
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

FILE: rtl/doiq_checker.sv
// Port-level checker for the deadline ordered input queue unit, bound to the top.
// Depends on doiq_pkg.
`timescale 1ns / 1ps
module doiq_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                res_valid,
  input doiq_pkg::out_item_t res_item
);
  import doiq_pkg::*;
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after transfer");
  a_no_res_idle: assert property (@(posedge clk) disable iff (rst)
    !$past(busy) && !busy |-> !res_valid) else $error("result while idle");
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !busy && !res_valid) else $error("activity after reset");
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.last_of_run |=> !res_valid)
    else $error("result straight after the last of a run");
endmodule

bind deadline_ordered_input_queue_unit doiq_checker u_doiq_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .res_valid(res_valid), .res_item(res_item));
